[hw/rtl/fac_pkg.sv]
package fac_pkg;

    // Plane register file.
    localparam int NUM_PLANE_REGS      = 6;
    localparam int PLANE_REG_W         = 64;
    localparam int REG_IDX_W           = 3;
    localparam int APB_ADDR_W          = 6;
    localparam int APB_BYTE_SEL_W      = 3;

    // Packed plane layout: nx, ny, nz Q1.14 then w Q8.8, 16 bits each.
    localparam int NORMAL_W            = 16;
    localparam int OFFSET_W            = 16;
    localparam int OFFSET_LSB          = 48;
    localparam int AXIS_COUNT          = 3;

    // w is Q8.8 and products are Q.22, so w is scaled up by 14 bits.
    localparam int OFFSET_SHIFT        = 14;
    localparam int OFFSET_SCALED_W     = OFFSET_W + OFFSET_SHIFT;

    localparam int DEFAULT_PLANE_COUNT = 6;
    localparam int DEFAULT_COORD_WIDTH = 16;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_INSIDE    = 2'd2
    } verdict_t;

endpackage

[hw/rtl/frustum_aabb_classify_unit.sv]
// Frustum versus axis-aligned box classifier (p-vertex / n-vertex test).
//
// Requests: a box (min_x..max_z, signed Q8.8) is taken at a rising clock edge
// where start is high and busy is low. busy is tied low, so a new request can
// be issued in every cycle and the block sustains one box per clock.
// Results: verdict (0 outside, 1 intersect, 2 inside) is shown for exactly one
// cycle with done high, after the request has passed the pipeline. The five
// register stages are corner selection, the coordinate-by-normal multipliers,
// two partial sums, the final sum with its sign test, and the verdict register.
// Results leave in request order. The receiver cannot stall the block, so no
// back-pressure path exists; every request yields exactly one result.
// Planes: six 64-bit registers on the APB port at byte address 8*i, written
// in the access cycle and readable at any time. Writes above plane 5 are
// dropped. Planes are meant to be changed only while no request is in flight.
// Reset: rst_n clears all plane registers to zero (every box is then outside)
// and empties the pipeline, so no stale done strobe appears after reset.
module frustum_aabb_classify_unit
    import fac_pkg::*;
#(
    parameter int PLANE_COUNT = DEFAULT_PLANE_COUNT,
    parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] min_x,
    input  logic signed [COORD_WIDTH-1:0] min_y,
    input  logic signed [COORD_WIDTH-1:0] min_z,
    input  logic signed [COORD_WIDTH-1:0] max_x,
    input  logic signed [COORD_WIDTH-1:0] max_y,
    input  logic signed [COORD_WIDTH-1:0] max_z,

    output logic                          done,
    output logic [1:0]                    verdict,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [PLANE_REG_W-1:0]        pwdata,
    output logic [PLANE_REG_W-1:0]        prdata,
    output logic                          pready
);

    // A product of a coordinate and a Q1.14 normal component.
    localparam int PROD_W = COORD_WIDTH + NORMAL_W;
    // Room for three products plus the scaled offset without overflow.
    localparam int BASE_W = (PROD_W > OFFSET_SCALED_W) ? PROD_W : OFFSET_SCALED_W;
    localparam int SUM_W  = BASE_W + 2;

    // Plane registers and APB port.
    logic [PLANE_REG_W-1:0] plane_reg [NUM_PLANE_REGS];
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:APB_BYTE_SEL_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANE_REGS; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_write && (reg_idx < REG_IDX_W'(NUM_PLANE_REGS)))
        begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx < REG_IDX_W'(NUM_PLANE_REGS))
        begin
            prdata = plane_reg[reg_idx];
        end
    end

    // Every stage advances each cycle, so the block never refuses a request.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage 1: pick the far (p) and near (n) corner coordinate per plane and
    // axis. A component that is zero or negative takes min for the far corner.
    logic signed [COORD_WIDTH-1:0] box_lo [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] box_hi [AXIS_COUNT];

    assign box_lo[0] = min_x;
    assign box_lo[1] = min_y;
    assign box_lo[2] = min_z;
    assign box_hi[0] = max_x;
    assign box_hi[1] = max_y;
    assign box_hi[2] = max_z;

    logic                          s1_valid_reg;
    logic signed [COORD_WIDTH-1:0] s1_far_reg   [PLANE_COUNT][AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] s1_near_reg  [PLANE_COUNT][AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] s1_far_next  [PLANE_COUNT][AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] s1_near_next [PLANE_COUNT][AXIS_COUNT];

    always_comb
    begin
        logic [NORMAL_W-1:0] comp;
        logic                comp_pos;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                comp     = plane_reg[p][a*NORMAL_W +: NORMAL_W];
                comp_pos = !comp[NORMAL_W-1] && (comp != '0);
                s1_far_next[p][a]  = comp_pos ? box_hi[a] : box_lo[a];
                s1_near_next[p][a] = comp_pos ? box_lo[a] : box_hi[a];
            end
        end
    end

    // Stage 2: one registered multiplier per corner, plane and axis.
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_far_prod_reg   [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] s2_near_prod_reg  [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] s2_far_prod_next  [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] s2_near_prod_next [PLANE_COUNT][AXIS_COUNT];

    always_comb
    begin
        logic signed [NORMAL_W-1:0] comp;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                comp = $signed(plane_reg[p][a*NORMAL_W +: NORMAL_W]);
                s2_far_prod_next[p][a]  = PROD_W'(s1_far_reg[p][a]) * PROD_W'(comp);
                s2_near_prod_next[p][a] = PROD_W'(s1_near_reg[p][a]) * PROD_W'(comp);
            end
        end
    end

    // Stage 3: two partial sums per corner, x+y and z+w.
    logic                    s3_valid_reg;
    logic signed [SUM_W-1:0] s3_far_xy_reg   [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_far_zw_reg   [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_near_xy_reg  [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_near_zw_reg  [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_far_xy_next  [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_far_zw_next  [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_near_xy_next [PLANE_COUNT];
    logic signed [SUM_W-1:0] s3_near_zw_next [PLANE_COUNT];

    always_comb
    begin
        logic signed [OFFSET_W-1:0] offset;
        logic signed [SUM_W-1:0]    offset_scaled;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            offset        = $signed(plane_reg[p][OFFSET_LSB +: OFFSET_W]);
            offset_scaled = SUM_W'(offset) <<< OFFSET_SHIFT;
            s3_far_xy_next[p]  = SUM_W'(s2_far_prod_reg[p][0]) + SUM_W'(s2_far_prod_reg[p][1]);
            s3_far_zw_next[p]  = SUM_W'(s2_far_prod_reg[p][2]) + offset_scaled;
            s3_near_xy_next[p] = SUM_W'(s2_near_prod_reg[p][0])
                               + SUM_W'(s2_near_prod_reg[p][1]);
            s3_near_zw_next[p] = SUM_W'(s2_near_prod_reg[p][2]) + offset_scaled;
        end
    end

    // Stage 4: final distance and the "at most zero" test per plane.
    logic                   s4_valid_reg;
    logic [PLANE_COUNT-1:0] s4_far_out_reg;
    logic [PLANE_COUNT-1:0] s4_near_out_reg;
    logic [PLANE_COUNT-1:0] s4_far_out_next;
    logic [PLANE_COUNT-1:0] s4_near_out_next;

    always_comb
    begin
        logic signed [SUM_W-1:0] far_d;
        logic signed [SUM_W-1:0] near_d;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            far_d  = s3_far_xy_reg[p] + s3_far_zw_reg[p];
            near_d = s3_near_xy_reg[p] + s3_near_zw_reg[p];
            s4_far_out_next[p]  = far_d[SUM_W-1] || (far_d == '0);
            s4_near_out_next[p] = near_d[SUM_W-1] || (near_d == '0);
        end
    end

    // Stage 5: verdict. Outside wins over intersect.
    logic     done_reg;
    verdict_t verdict_reg;
    verdict_t verdict_next;

    always_comb
    begin
        if (|s4_far_out_reg)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (|s4_near_out_reg)
        begin
            verdict_next = VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = VERDICT_INSIDE;
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Payload registers; they load freely since the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        s1_far_reg       <= s1_far_next;
        s1_near_reg      <= s1_near_next;
        s2_far_prod_reg  <= s2_far_prod_next;
        s2_near_prod_reg <= s2_near_prod_next;
        s3_far_xy_reg    <= s3_far_xy_next;
        s3_far_zw_reg    <= s3_far_zw_next;
        s3_near_xy_reg   <= s3_near_xy_next;
        s3_near_zw_reg   <= s3_near_zw_next;
        s4_far_out_reg   <= s4_far_out_next;
        s4_near_out_reg  <= s4_near_out_next;
        verdict_reg      <= verdict_next;
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

    // Every accepted request produces its strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("request did not produce a result after five cycles");

    // No strobe appears without a matching earlier request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result strobe without a matching request");

    // A plane whose far corner is not in front forces an outside verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && (|s4_far_out_reg)) |=> (done && (verdict == VERDICT_OUTSIDE)))
        else $error("far corner behind a plane but verdict is not outside");

    // With all far corners in front, a near corner behind a plane means intersect.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !(|s4_far_out_reg) && (|s4_near_out_reg))
        |=> (done && (verdict == VERDICT_INTERSECT)))
        else $error("near corner behind a plane but verdict is not intersect");

endmodule
